@@ src/l0_gradient_threshold_macros.svh @@
`ifndef L0_GRADIENT_THRESHOLD_MACROS_SVH
`define L0_GRADIENT_THRESHOLD_MACROS_SVH

// Same-cycle implication, not checked while reset is asserted.
`define L0GT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("l0gt check failed");

// Next-cycle implication, not checked while reset is asserted.
`define L0GT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("l0gt check failed");

// Next-cycle implication that is also checked through reset.
`define L0GT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("l0gt check failed");

`endif

@@ src/l0gt_pkg.sv @@
`timescale 1ns / 1ps

package l0gt_pkg;

    // Register file layout.
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 35;
    localparam int THR_W        = 35;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd2048;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd2048;

    // Row geometry.
    localparam int ROW_W    = 12;
    localparam int MAX_ROWS = 4096;

    // One write on the configuration port.
    typedef struct packed {
        logic                   write;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

    // Sideband that travels with each result through the gradient pipeline.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             image_done;
    } res_tag_t;

endpackage

@@ src/l0gt_pixel_if.sv @@
`timescale 1ns / 1ps

interface l0gt_pixel_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] chan_a;
    logic signed [SAMPLE_BITS-1:0] chan_b;
    logic signed [SAMPLE_BITS-1:0] chan_c;

    modport source (output valid, output chan_a, output chan_b, output chan_c, input ready);
    modport sink (input valid, input chan_a, input chan_b, input chan_c, output ready);
endinterface

@@ src/l0gt_result_if.sv @@
`timescale 1ns / 1ps

interface l0gt_result_if import l0gt_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int COL_W = 11
);
    logic                          valid;
    logic                          ready;
    logic [ROW_W-1:0]              row_index;
    logic [COL_W-1:0]              col_index;
    logic signed [SAMPLE_BITS:0]   horiz_a;
    logic signed [SAMPLE_BITS:0]   horiz_b;
    logic signed [SAMPLE_BITS:0]   horiz_c;
    logic signed [SAMPLE_BITS:0]   vert_a;
    logic signed [SAMPLE_BITS:0]   vert_b;
    logic signed [SAMPLE_BITS:0]   vert_c;
    logic                          suppressed;
    logic                          image_done;

    modport source (
        output valid, output row_index, output col_index,
        output horiz_a, output horiz_b, output horiz_c,
        output vert_a, output vert_b, output vert_c,
        output suppressed, output image_done,
        input ready
    );
    modport sink (
        input valid, input row_index, input col_index,
        input horiz_a, input horiz_b, input horiz_c,
        input vert_a, input vert_b, input vert_c,
        input suppressed, input image_done,
        output ready
    );
endinterface

@@ src/l0_gradient_threshold.sv @@
// Path: the pixel that completes a result word is held in the pixel register, and the word
// then passes the difference, square, pair sum and compare stages, where a stall can hold it.
// Throughput: one pixel per cycle unless the results stall, but only one result enters the
// pipeline per cycle, so a last-row pixel waits for all its results (first of row one, final pixel three).
// Reset: counters, pipeline valids and registers (threshold 0, width and height 2048) clear
// at once; the line and first-row stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module l0_gradient_threshold import l0gt_pkg::*; #(
    parameter int MAX_COLS = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    l0gt_pixel_if.sink             pixel,
    l0gt_result_if.source          result
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int PIX_W = 3 * SAMPLE_BITS;

    cfg_write_t       cfg;
    logic             issue_valid;
    logic             issue_ready;
    res_tag_t         issue_tag;
    logic [COL_W-1:0] issue_col;
    logic [PIX_W-1:0] issue_cur;
    logic [PIX_W-1:0] issue_right;
    logic [PIX_W-1:0] issue_below;

    // Bundle the configuration write for both units.
    assign cfg.write = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // Raster tracking, neighbor stores and result sequencing.
    l0gt_ctrl #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pixel       (pixel),
        .issue_valid (issue_valid),
        .issue_ready (issue_ready),
        .issue_tag   (issue_tag),
        .issue_col   (issue_col),
        .issue_cur   (issue_cur),
        .issue_right (issue_right),
        .issue_below (issue_below)
    );

    // Gradient, energy and threshold pipeline.
    l0gt_grad #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COL_W       (COL_W)
    ) u_grad (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .issue_valid (issue_valid),
        .issue_ready (issue_ready),
        .issue_tag   (issue_tag),
        .issue_col   (issue_col),
        .issue_cur   (issue_cur),
        .issue_right (issue_right),
        .issue_below (issue_below),
        .result      (result)
    );

endmodule

@@ src/l0gt_ctrl.sv @@
`timescale 1ns / 1ps

module l0gt_ctrl import l0gt_pkg::*; #(
    parameter int MAX_COLS = 2048,
    parameter int SAMPLE_BITS = 16,
    localparam int COL_W = $clog2(MAX_COLS),
    localparam int PIX_W = 3 * SAMPLE_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_write_t        cfg,
    l0gt_pixel_if.sink        pixel,
    output logic              issue_valid,
    input  logic              issue_ready,
    output res_tag_t          issue_tag,
    output logic [COL_W-1:0]  issue_col,
    output logic [PIX_W-1:0]  issue_cur,
    output logic [PIX_W-1:0]  issue_right,
    output logic [PIX_W-1:0]  issue_below
);

    localparam int WCMP_W = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;

    // Pending-result bits of the held pixel, issued lowest first.
    localparam int PEND_UP   = 0;
    localparam int PEND_LEFT = 1;
    localparam int PEND_OWN  = 2;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [ROW_W-1:0]        row_count_reg;
    logic [COL_W-1:0]        col_count_reg;
    logic [PIX_W-1:0]        prev_row_first_reg;
    logic [PIX_W-1:0]        cur_row_first_reg;
    logic [2:0]              pend_reg;
    logic [2:0]              pend_after;
    logic [2:0]              pend_new;

    logic [PIX_W-1:0]        line_store [MAX_COLS];
    logic [PIX_W-1:0]        top_store [MAX_COLS];
    logic [PIX_W-1:0]        line_rd_reg;
    logic [PIX_W-1:0]        top_rd_reg;

    logic [PIX_W-1:0]        s1_pix_reg;
    logic [PIX_W-1:0]        s1_left_reg;
    logic [PIX_W-1:0]        s1_up_reg;
    logic [PIX_W-1:0]        s1_top_prev_reg;
    logic [ROW_W-1:0]        s1_row_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic                    s1_row_end_reg;

    logic [WCMP_W-1:0]       width_eff;
    logic [HEIGHT_REG_W-1:0] height_eff;
    logic                    row_end;
    logic                    last_row;
    logic                    accept;
    logic [PIX_W-1:0]        pix_in;
    logic [COL_W-1:0]        rd_addr;

    // Image size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg.write)
        begin
            if (cfg.index == REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg.data[WIDTH_REG_W-1:0];
            end
            if (cfg.index == REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg.data[HEIGHT_REG_W-1:0];
            end
        end
    end

    // Clamp the size registers to the supported range.
    always_comb
    begin
        width_eff = WCMP_W'(width_reg);
        if (width_eff < WCMP_W'(2))
        begin
            width_eff = WCMP_W'(2);
        end
        else if (width_eff > WCMP_W'(MAX_COLS))
        begin
            width_eff = WCMP_W'(MAX_COLS);
        end

        height_eff = height_reg;
        if (height_eff < HEIGHT_REG_W'(2))
        begin
            height_eff = HEIGHT_REG_W'(2);
        end
        else if (height_eff > HEIGHT_REG_W'(MAX_ROWS))
        begin
            height_eff = HEIGHT_REG_W'(MAX_ROWS);
        end
    end

    assign row_end  = WCMP_W'(col_count_reg) >= (width_eff - WCMP_W'(1));
    assign last_row = HEIGHT_REG_W'(row_count_reg) >= (height_eff - HEIGHT_REG_W'(1));
    assign pix_in   = {pixel.chan_c, pixel.chan_b, pixel.chan_a};

    // Results the incoming pixel completes: the pixel above it, and on the
    // last row also the pixel to its left and, at the row end, itself.
    assign pend_new[PEND_UP]   = (row_count_reg != '0);
    assign pend_new[PEND_LEFT] = last_row && (col_count_reg != '0);
    assign pend_new[PEND_OWN]  = last_row && row_end;

    // Pick the next result of the held pixel, with the pixel it belongs to and its two neighbors.
    always_comb
    begin
        issue_valid            = |pend_reg;
        pend_after             = pend_reg;
        issue_tag.row          = s1_row_reg;
        issue_tag.image_done   = 1'b0;
        issue_col              = s1_col_reg;
        issue_cur              = s1_pix_reg;
        issue_right            = cur_row_first_reg;
        issue_below            = top_rd_reg;
        priority if (pend_reg[PEND_UP])
        begin
            issue_tag.row = s1_row_reg - ROW_W'(1);
            issue_cur     = s1_up_reg;
            issue_right   = s1_row_end_reg ? prev_row_first_reg : line_rd_reg;
            issue_below   = s1_pix_reg;
            if (issue_ready)
            begin
                pend_after[PEND_UP] = 1'b0;
            end
        end
        else if (pend_reg[PEND_LEFT])
        begin
            issue_col   = s1_col_reg - COL_W'(1);
            issue_cur   = s1_left_reg;
            issue_right = s1_pix_reg;
            issue_below = s1_top_prev_reg;
            if (issue_ready)
            begin
                pend_after[PEND_LEFT] = 1'b0;
            end
        end
        else if (pend_reg[PEND_OWN])
        begin
            issue_tag.image_done = 1'b1;
            if (issue_ready)
            begin
                pend_after[PEND_OWN] = 1'b0;
            end
        end
        else
        begin
            pend_after = pend_reg;
        end
    end

    // A new word enters once the held pixel has handed over its last result.
    assign pixel.ready = (pend_after == '0);
    assign accept      = pixel.valid && pixel.ready;

    // Raster counters, first-of-row pixels and the pending mask.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg      <= '0;
            col_count_reg      <= '0;
            prev_row_first_reg <= '0;
            cur_row_first_reg  <= '0;
            pend_reg           <= '0;
        end
        else
        begin
            pend_reg <= accept ? pend_new : pend_after;
            if (accept)
            begin
                if (row_end)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= last_row ? '0 : row_count_reg + ROW_W'(1);
                end
                else
                begin
                    col_count_reg <= col_count_reg + COL_W'(1);
                end
                if (col_count_reg == '0)
                begin
                    prev_row_first_reg <= cur_row_first_reg;
                    cur_row_first_reg  <= pix_in;
                end
            end
        end
    end

    // Read one column ahead, so the current column arrives with the next pixel.
    assign rd_addr = row_end ? '0 : col_count_reg + COL_W'(1);

    // Line store: previous row.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_store[col_count_reg] <= pix_in;
            line_rd_reg               <= line_store[rd_addr];
        end
    end

    // First-row store: written on row zero, read on the last row.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (row_count_reg == '0)
            begin
                top_store[col_count_reg] <= pix_in;
            end
            top_rd_reg <= top_store[col_count_reg];
        end
    end

    // Held pixel and the neighbors gathered for it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg      <= pix_in;
            s1_left_reg     <= s1_pix_reg;
            s1_up_reg       <= (col_count_reg == '0) ? cur_row_first_reg : line_rd_reg;
            s1_top_prev_reg <= top_rd_reg;
            s1_row_reg      <= row_count_reg;
            s1_col_reg      <= col_count_reg;
            s1_row_end_reg  <= row_end;
        end
    end

endmodule

@@ src/l0gt_grad.sv @@
`timescale 1ns / 1ps

module l0gt_grad import l0gt_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int COL_W = 11,
    localparam int PIX_W = 3 * SAMPLE_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_write_t        cfg,
    input  logic              issue_valid,
    output logic              issue_ready,
    input  res_tag_t          issue_tag,
    input  logic [COL_W-1:0]  issue_col,
    input  logic [PIX_W-1:0]  issue_cur,
    input  logic [PIX_W-1:0]  issue_right,
    input  logic [PIX_W-1:0]  issue_below,
    l0gt_result_if.source     result
);

    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS;
    localparam int PAIR_W = SQ_W + 1;
    localparam int SUM_W  = SQ_W + 3;
    localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

    logic [THR_W-1:0] threshold_reg;

    logic signed [SAMPLE_BITS-1:0] cur_ch   [3];
    logic signed [SAMPLE_BITS-1:0] right_ch [3];
    logic signed [SAMPLE_BITS-1:0] below_ch [3];
    logic signed [2*DIFF_W-1:0]    prod_h   [3];
    logic signed [2*DIFF_W-1:0]    prod_v   [3];
    logic [SUM_W-1:0]              total;
    logic                          sup;

    logic d_ready;
    logic q_ready;
    logic t_ready;
    logic o_ready;

    logic                     d_valid_reg;
    res_tag_t                 d_tag_reg;
    logic [COL_W-1:0]         d_col_reg;
    logic signed [DIFF_W-1:0] d_h_reg [3];
    logic signed [DIFF_W-1:0] d_v_reg [3];

    logic                     q_valid_reg;
    res_tag_t                 q_tag_reg;
    logic [COL_W-1:0]         q_col_reg;
    logic signed [DIFF_W-1:0] q_h_reg [3];
    logic signed [DIFF_W-1:0] q_v_reg [3];
    logic [SQ_W-1:0]          q_sqh_reg [3];
    logic [SQ_W-1:0]          q_sqv_reg [3];

    logic                     t_valid_reg;
    res_tag_t                 t_tag_reg;
    logic [COL_W-1:0]         t_col_reg;
    logic signed [DIFF_W-1:0] t_h_reg [3];
    logic signed [DIFF_W-1:0] t_v_reg [3];
    logic [PAIR_W-1:0]        t_pair_reg [3];

    logic                     o_valid_reg;
    res_tag_t                 o_tag_reg;
    logic [COL_W-1:0]         o_col_reg;
    logic signed [DIFF_W-1:0] o_h_reg [3];
    logic signed [DIFF_W-1:0] o_v_reg [3];
    logic                     o_sup_reg;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg.write && (cfg.index == REG_THRESHOLD))
        begin
            threshold_reg <= cfg.data[THR_W-1:0];
        end
    end

    // Each stage moves when the stage after it is empty or moving.
    assign o_ready     = !o_valid_reg || result.ready;
    assign t_ready     = !t_valid_reg || o_ready;
    assign q_ready     = !q_valid_reg || t_ready;
    assign d_ready     = !d_valid_reg || q_ready;
    assign issue_ready = d_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (d_ready)
            begin
                d_valid_reg <= issue_valid;
            end
            if (q_ready)
            begin
                q_valid_reg <= d_valid_reg;
            end
            if (t_ready)
            begin
                t_valid_reg <= q_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= t_valid_reg;
            end
        end
    end

    // Split the packed pixels into channels.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cur_ch[k]   = issue_cur[k*SAMPLE_BITS +: SAMPLE_BITS];
            right_ch[k] = issue_right[k*SAMPLE_BITS +: SAMPLE_BITS];
            below_ch[k] = issue_below[k*SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    // Difference stage: right and lower forward differences.
    always_ff @(posedge clk)
    begin
        if (d_ready && issue_valid)
        begin
            d_tag_reg <= issue_tag;
            d_col_reg <= issue_col;
            for (int k = 0; k < 3; k++)
            begin
                d_h_reg[k] <= DIFF_W'(right_ch[k]) - DIFF_W'(cur_ch[k]);
                d_v_reg[k] <= DIFF_W'(below_ch[k]) - DIFF_W'(cur_ch[k]);
            end
        end
    end

    // Square stage: six squares in parallel; they fit SQ_W bits unsigned.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_h[k] = d_h_reg[k] * d_h_reg[k];
            prod_v[k] = d_v_reg[k] * d_v_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_ready && d_valid_reg)
        begin
            q_tag_reg <= d_tag_reg;
            q_col_reg <= d_col_reg;
            for (int k = 0; k < 3; k++)
            begin
                q_h_reg[k]   <= d_h_reg[k];
                q_v_reg[k]   <= d_v_reg[k];
                q_sqh_reg[k] <= prod_h[k][SQ_W-1:0];
                q_sqv_reg[k] <= prod_v[k][SQ_W-1:0];
            end
        end
    end

    // Pair stage: per-channel sum of the two squares.
    always_ff @(posedge clk)
    begin
        if (t_ready && q_valid_reg)
        begin
            t_tag_reg <= q_tag_reg;
            t_col_reg <= q_col_reg;
            for (int k = 0; k < 3; k++)
            begin
                t_h_reg[k]    <= q_h_reg[k];
                t_v_reg[k]    <= q_v_reg[k];
                t_pair_reg[k] <= PAIR_W'(q_sqh_reg[k]) + PAIR_W'(q_sqv_reg[k]);
            end
        end
    end

    // Final sum and threshold compare.
    assign total = SUM_W'(t_pair_reg[0]) + SUM_W'(t_pair_reg[1]) + SUM_W'(t_pair_reg[2]);
    assign sup   = CMP_W'(total) <= CMP_W'(threshold_reg);

    // Output register: suppressed gradients leave as zero.
    always_ff @(posedge clk)
    begin
        if (o_ready && t_valid_reg)
        begin
            o_tag_reg <= t_tag_reg;
            o_col_reg <= t_col_reg;
            o_sup_reg <= sup;
            for (int k = 0; k < 3; k++)
            begin
                o_h_reg[k] <= sup ? '0 : t_h_reg[k];
                o_v_reg[k] <= sup ? '0 : t_v_reg[k];
            end
        end
    end

    assign result.valid      = o_valid_reg;
    assign result.row_index  = o_tag_reg.row;
    assign result.col_index  = o_col_reg;
    assign result.horiz_a    = o_h_reg[0];
    assign result.horiz_b    = o_h_reg[1];
    assign result.horiz_c    = o_h_reg[2];
    assign result.vert_a     = o_v_reg[0];
    assign result.vert_b     = o_v_reg[1];
    assign result.vert_c     = o_v_reg[2];
    assign result.suppressed = o_sup_reg;
    assign result.image_done = o_tag_reg.image_done;

endmodule

@@ src/l0gt_checker.sv @@
`timescale 1ns / 1ps
`include "l0_gradient_threshold_macros.svh"

module l0gt_checker import l0gt_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int COL_W = 11
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic [ROW_W-1:0]             res_row,
    input logic [COL_W-1:0]             res_col,
    input logic [6*(SAMPLE_BITS+1)-1:0] res_diffs,
    input logic                         res_suppressed,
    input logic                         res_done
);

    logic [ROW_W+COL_W+6*(SAMPLE_BITS+1)+1:0] res_word;

    assign res_word = {res_row, res_col, res_diffs, res_suppressed, res_done};

    // A suppressed word carries all six gradients as zero.
    `L0GT_ASSERT_SAME(a_sup_zero, clk, rst_n, res_valid && res_suppressed, res_diffs == '0)

    // The final word of an image never belongs to row zero.
    `L0GT_ASSERT_SAME(a_done_row, clk, rst_n, res_valid && res_done, res_row != '0)

    // A stalled result word stays and holds its contents.
    `L0GT_ASSERT_NEXT(a_stall_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_word))

    // Nothing is offered in the cycle after reset is seen.
    `L0GT_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, !res_valid)

endmodule

bind l0_gradient_threshold l0gt_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COL_W       ($clog2(MAX_COLS))
) u_l0gt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_row        (result.row_index),
    .res_col        (result.col_index),
    .res_diffs      ({result.horiz_a, result.horiz_b, result.horiz_c,
                      result.vert_a, result.vert_b, result.vert_c}),
    .res_suppressed (result.suppressed),
    .res_done       (result.image_done)
);

@@ verif/l0_gradient_threshold_tb.sv @@
`timescale 1ns / 1ps

module l0_gradient_threshold_tb;
    import l0gt_pkg::*;

    localparam int LINE_DEPTH = 2048;
    localparam int SAMPLE_W   = 16;
    localparam int COL_BITS   = 11;
    localparam int HOLD_OFF   = 12;

    // The register map has one index that selects nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        logic signed [SAMPLE_W-1:0] c;
    } pixel_t;

    typedef struct {
        logic [ROW_W-1:0]          row;
        logic [COL_BITS-1:0]       col;
        logic signed [SAMPLE_W:0]  ha;
        logic signed [SAMPLE_W:0]  hb;
        logic signed [SAMPLE_W:0]  hc;
        logic signed [SAMPLE_W:0]  va;
        logic signed [SAMPLE_W:0]  vb;
        logic signed [SAMPLE_W:0]  vc;
        logic                      sup;
        logic                      done;
    } grad_word_t;

    typedef enum int {TEX_NOISE, TEX_SMOOTH, TEX_EXTREME} texture_t;
    typedef enum int {FLOW_FREE, FLOW_SEND_GAPS, FLOW_RECV_STALLS, FLOW_BOTH} flow_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic px_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] px_a = '0;
    logic signed [SAMPLE_W-1:0] px_b = '0;
    logic signed [SAMPLE_W-1:0] px_c = '0;
    logic rs_ready = 1'b0;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    pixel_t pixel_queue[$];
    grad_word_t grad_expect[$];

    // Predictor copy of the block's registers and stores.
    logic [THR_W-1:0] thr_cfg = '0;
    logic [WIDTH_REG_W-1:0] width_cfg = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] height_cfg = HEIGHT_RESET;
    pixel_t line_mem [LINE_DEPTH];
    pixel_t top_mem [LINE_DEPTH];
    pixel_t prev_first = '0;
    pixel_t cur_first = '0;
    pixel_t last_px = '0;
    int row_ctr = 0;
    int col_ctr = 0;

    l0gt_pixel_if #(.SAMPLE_BITS(SAMPLE_W)) pix_if ();
    l0gt_result_if #(.SAMPLE_BITS(SAMPLE_W), .COL_W(COL_BITS)) res_if ();

    assign pix_if.valid  = px_valid;
    assign pix_if.chan_a = px_a;
    assign pix_if.chan_b = px_b;
    assign pix_if.chan_c = px_c;
    assign res_if.ready  = rs_ready;

    l0_gradient_threshold #(
        .MAX_COLS(LINE_DEPTH),
        .SAMPLE_BITS(SAMPLE_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel(pix_if),
        .result(res_if)
    );

    always #4 clk = ~clk;

    // Build one gradient word from a pixel and its two neighbors.
    function automatic grad_word_t make_word(int row, int col, pixel_t cur, pixel_t right,
                                             pixel_t below, logic done);
        grad_word_t w;
        logic signed [SAMPLE_W:0] dh [3];
        logic signed [SAMPLE_W:0] dv [3];
        longint sum;
        dh[0] = right.a - cur.a;
        dh[1] = right.b - cur.b;
        dh[2] = right.c - cur.c;
        dv[0] = below.a - cur.a;
        dv[1] = below.b - cur.b;
        dv[2] = below.c - cur.c;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            sum += longint'(dh[i]) * longint'(dh[i]);
            sum += longint'(dv[i]) * longint'(dv[i]);
        end
        w.sup  = (sum <= longint'(thr_cfg));
        w.row  = ROW_W'(row);
        w.col  = COL_BITS'(col);
        w.ha   = w.sup ? '0 : dh[0];
        w.hb   = w.sup ? '0 : dh[1];
        w.hc   = w.sup ? '0 : dh[2];
        w.va   = w.sup ? '0 : dv[0];
        w.vb   = w.sup ? '0 : dv[1];
        w.vc   = w.sup ? '0 : dv[2];
        w.done = done;
        return w;
    endfunction

    // Advance the raster position by one accepted pixel and queue the words it completes.
    function automatic void advance_pixel(pixel_t p);
        int w;
        int hgt;
        int r;
        int c;
        logic row_end;
        logic last_row;
        pixel_t right;
        w = int'(width_cfg);
        hgt = int'(height_cfg);
        if (w < 2) w = 2;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        if (hgt < 2) hgt = 2;
        if (hgt > MAX_ROWS) hgt = MAX_ROWS;
        r = row_ctr;
        c = col_ctr;
        if (c >= LINE_DEPTH) c = LINE_DEPTH - 1;
        row_end = (c >= w - 1);
        last_row = (r >= hgt - 1);

        if (c == 0)
        begin
            prev_first = cur_first;
            cur_first = p;
        end
        if (r >= 1)
        begin
            if (row_end)
                right = prev_first;
            else
                right = line_mem[c + 1];
            grad_expect.push_back(make_word(r - 1, c, line_mem[c], right, p, 1'b0));
        end
        if (last_row)
        begin
            if (c >= 1)
                grad_expect.push_back(make_word(r, c - 1, last_px, p, top_mem[c - 1], 1'b0));
            if (row_end)
                grad_expect.push_back(make_word(r, c, p, cur_first, top_mem[c], 1'b1));
        end

        if (r == 0)
            top_mem[c] = p;
        line_mem[c] = p;
        last_px = p;

        if (row_end)
        begin
            col_ctr = 0;
            row_ctr = last_row ? 0 : r + 1;
        end
        else
        begin
            col_ctr = c + 1;
        end
    endfunction

    // Pixel driver: presents queued pixels, with random gaps between words.
    always @(posedge clk or negedge rst_n)
    begin : drive_pixels
        pixel_t next_px;
        if (!rst_n)
        begin
            px_valid <= 1'b0;
            px_a <= '0;
            px_b <= '0;
            px_c <= '0;
        end
        else
        begin
            if (px_valid && pix_if.ready)
                advance_pixel({px_a, px_b, px_c});
            if (!px_valid || pix_if.ready)
            begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    next_px = pixel_queue.pop_front();
                    px_valid <= 1'b1;
                    px_a <= next_px.a;
                    px_b <= next_px.b;
                    px_c <= next_px.c;
                end
                else
                begin
                    px_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Result monitor: compares each accepted word with the oldest expected one.
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        grad_word_t want;
        if (!rst_n)
        begin
            rs_ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && rs_ready)
            begin
                if (grad_expect.size() == 0)
                begin
                    $error("unexpected result word: row %0d col %0d",
                           res_if.row_index, res_if.col_index);
                    mismatch_count++;
                end
                else
                begin
                    want = grad_expect.pop_front();
                    check_field("row_index", want.row, res_if.row_index);
                    check_field("col_index", want.col, res_if.col_index);
                    check_field("horiz_a", want.ha, res_if.horiz_a);
                    check_field("horiz_b", want.hb, res_if.horiz_b);
                    check_field("horiz_c", want.hc, res_if.horiz_c);
                    check_field("vert_a", want.va, res_if.vert_a);
                    check_field("vert_b", want.vb, res_if.vert_b);
                    check_field("vert_c", want.vc, res_if.vert_c);
                    check_field("suppressed", want.sup, res_if.suppressed);
                    check_field("image_done", want.done, res_if.image_done);
                end
            end
            rs_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Register write; the predictor copy changes at the same edge as the block.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_THRESHOLD:    thr_cfg = val[THR_W-1:0];
            REG_IMAGE_WIDTH:  width_cfg = val[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_cfg = val[HEIGHT_REG_W-1:0];
            default:          ;
        endcase
    endtask

    // Size writes carry random junk above the register width.
    task automatic set_width(int w);
        write_reg(REG_IMAGE_WIDTH,
                  (CFG_DATA_W'($urandom) << WIDTH_REG_W) | CFG_DATA_W'(w));
    endtask

    task automatic set_height(int h);
        write_reg(REG_IMAGE_HEIGHT,
                  (CFG_DATA_W'($urandom) << HEIGHT_REG_W) | CFG_DATA_W'(h));
    endtask

    task automatic set_flow(flow_t mode);
        case (mode)
            FLOW_FREE:        begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            FLOW_SEND_GAPS:   begin send_gap_pct = 45; recv_stall_pct = 0;  end
            FLOW_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 45; end
            default:          begin send_gap_pct = 23; recv_stall_pct = 23; end
        endcase
    endtask

    // Wait until every pixel is taken and every word has come back, then let the
    // pipeline settle, since row zero pixels leave no word behind them.
    task automatic wait_idle();
        while (pixel_queue.size() != 0 || px_valid || grad_expect.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    function automatic pixel_t make_pixel(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        pixel_t p;
        p.a = a;
        p.b = b;
        p.c = c;
        return p;
    endfunction

    function automatic logic [15:0] pick_sample(texture_t tex, logic [15:0] base);
        case (tex)
            TEX_NOISE:  return 16'($urandom);
            TEX_SMOOTH: return base + 16'($urandom_range(31)) - 16'd16;
            default:
            begin
                case ($urandom_range(5))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    3:       return 16'hFFFF;
                    default: return 16'($urandom);
                endcase
            end
        endcase
    endfunction

    // Queue one whole image in raster order.
    task automatic push_image(int w, int h, texture_t tex);
        logic [15:0] base [3];
        for (int i = 0; i < 3; i++)
            base[i] = 16'($urandom);
        for (int n = 0; n < w * h; n++)
            pixel_queue.push_back(make_pixel(pick_sample(tex, base[0]),
                                             pick_sample(tex, base[1]),
                                             pick_sample(tex, base[2])));
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_threshold(texture_t tex);
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'({$urandom, $urandom});
            default: return (tex == TEX_SMOOTH) ? CFG_DATA_W'($urandom_range(6000))
                                                : CFG_DATA_W'({$urandom_range(7), $urandom});
        endcase
    endfunction

    // Stimulus sequence.
    initial
    begin
        int random_items;
        int phase;
        int w;
        int h;
        int eff_w;
        int eff_h;
        texture_t tex;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        set_flow(FLOW_FREE);

        // Full-scale samples and alternating bit patterns on a 3 x 2 image.
        write_reg(REG_THRESHOLD, '0);
        set_width(3);
        set_height(2);
        pixel_queue.push_back(make_pixel(16'h7FFF, 16'h8000, 16'h0000));
        pixel_queue.push_back(make_pixel(16'h8000, 16'h7FFF, 16'hFFFF));
        pixel_queue.push_back(make_pixel(16'h0000, 16'hFFFF, 16'h7FFF));
        pixel_queue.push_back(make_pixel(16'hFFFF, 16'h0000, 16'h8000));
        pixel_queue.push_back(make_pixel(16'h5555, 16'hAAAA, 16'h0F0F));
        pixel_queue.push_back(make_pixel(16'hAAAA, 16'h5555, 16'hF0F0));
        wait_idle();

        // A flat image is suppressed even at a zero threshold.
        set_width(2);
        for (int i = 0; i < 4; i++)
            pixel_queue.push_back(make_pixel(16'd1234, 16'hFFFB, 16'd77));
        wait_idle();

        // The largest threshold suppresses even the steepest gradients.
        write_reg(REG_THRESHOLD, '1);
        pixel_queue.push_back(make_pixel(16'h7FFF, 16'h8000, 16'h7FFF));
        pixel_queue.push_back(make_pixel(16'h8000, 16'h7FFF, 16'h8000));
        pixel_queue.push_back(make_pixel(16'h8000, 16'h7FFF, 16'h8000));
        pixel_queue.push_back(make_pixel(16'h7FFF, 16'h8000, 16'h7FFF));
        wait_idle();

        // Sizes under the minimum clamp to 2 x 2; sums of one land exactly on the bound.
        write_reg(REG_THRESHOLD, CFG_DATA_W'(1));
        set_width(1);
        set_height(0);
        pixel_queue.push_back(make_pixel(16'd1, 16'd0, 16'd0));
        for (int i = 0; i < 3; i++)
            pixel_queue.push_back(make_pixel(16'd0, 16'd0, 16'd0));
        wait_idle();

        // A write to the spare index must leave every register alone.
        write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));

        // Shrink both sizes in the middle of a row: the column already sits past the
        // new width, so the row ends, and the row count makes it the last row.
        write_reg(REG_THRESHOLD, '0);
        set_width(3);
        set_height(3);
        for (int i = 0; i < 5; i++)
            pixel_queue.push_back(make_pixel(16'($urandom), 16'($urandom), 16'($urandom)));
        wait_idle();
        set_width(2);
        set_height(2);
        pixel_queue.push_back(make_pixel(16'($urandom), 16'($urandom), 16'($urandom)));
        wait_idle();

        // Random small images with random thresholds and flow control.
        random_items = 0;
        phase = 0;
        while (random_items < 140)
        begin
            set_flow(flow_t'(phase % 4));
            phase++;
            tex = texture_t'($urandom_range(2));
            w = $urandom_range(8);
            h = $urandom_range(5);
            eff_w = (w < 2) ? 2 : w;
            eff_h = (h < 2) ? 2 : h;
            if ($urandom_range(3) != 0)
                write_reg(REG_THRESHOLD, random_threshold(tex));
            set_width(w);
            set_height(h);
            push_image(eff_w, eff_h, tex);
            random_items += eff_w * eff_h;
            wait_idle();
        end

        // One more small image at the end, with no gaps or stalls.
        set_flow(FLOW_FREE);
        set_width(4);
        set_height(3);
        push_image(4, 3, TEX_EXTREME);
        wait_idle();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && grad_expect.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Run limit.
    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/l0gt_pkg.sv
src/l0gt_pixel_if.sv
src/l0gt_result_if.sv
src/l0gt_ctrl.sv
src/l0gt_grad.sv
src/l0_gradient_threshold.sv
src/l0gt_checker.sv
verif/l0_gradient_threshold_tb.sv
